### design/cpds_pkg.sv
// cart-pole step package: fixed-point formats, physics constants, sequencer states
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps
`default_nettype none

package cpds_pkg;

   // state format and internal datapath word
   localparam int FRAC_BITS = 24;
   localparam int FX_W      = 32;
   localparam int WORD_W    = 34;

   typedef logic signed [FX_W-1:0]   fx_type;
   typedef logic signed [WORD_W-1:0] word_type;

   // constants in Q.30
   localparam longint ONE30         = 64'sd1073741824;
   localparam longint K_GRAVITY     = 64'sd10522669875;
   localparam longint K_PML         = 64'sd53687091;
   localparam longint K_INV_TM      = 64'sd976128931;
   localparam longint K_LEN         = 64'sd536870912;
   localparam longint K_FOUR_THIRDS = 64'sd1431655765;
   localparam longint K_MP_TM       = 64'sd97612893;
   localparam longint K_PML_TM      = 64'sd48806447;
   localparam longint K_TAU         = 64'sd21474836;
   localparam longint K_X_THR       = 64'sd2576980378;
   localparam longint K_TH_THR      = 64'sd224883962;

   // angle reduction constants in Q.32
   localparam longint A_TWO_PI  = 64'sd26986075409;
   localparam longint A_PI      = 64'sd13493037705;
   localparam longint A_HALF_PI = 64'sd6746518852;

   // Q.30 constant to state format, rounded and saturated
   function automatic longint kf(input longint k30);
      longint v;
      v = (k30 + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      return v;
   endfunction

   // push force magnitude in state format, saturated
   function automatic longint push_force();
      longint v;
      v = longint'(10) << FRAC_BITS;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      return v;
   endfunction

   localparam fx_type KG_FX     = FX_W'(kf(K_GRAVITY));
   localparam fx_type X_THR_FX  = FX_W'(kf(K_X_THR));
   localparam fx_type TH_THR_FX = FX_W'(kf(K_TH_THR));
   localparam fx_type FORCE_FX  = FX_W'(push_force());

   // angle reduction: state angle scaled to Q.32, remainder by subtract steps
   localparam int MOD_SH  = 32 - FRAC_BITS;
   localparam int MOD_W   = 64 - FRAC_BITS;
   localparam int MOD_TOP = 29 - FRAC_BITS;

   // long division steps and the shared step counter
   localparam int DIV_STEPS = 62;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   // multiplier shift amounts
   localparam logic [5:0] SH_FX  = 6'(FRAC_BITS);
   localparam logic [5:0] SH_30  = 6'd30;
   localparam logic [5:0] SH_RCP = 6'd32;

   // taylor divisors and their reciprocals (2^32 / d, floored), indexed by term
   localparam longint RCP_NUM = 64'sd4294967296;
   localparam logic [7:0] SIN_DIV [8] = '{8'd0, 8'd6, 8'd20, 8'd42, 8'd72, 8'd110,
                                          8'd156, 8'd210};
   localparam logic [7:0] COS_DIV [8] = '{8'd0, 8'd2, 8'd12, 8'd30, 8'd56, 8'd90,
                                          8'd132, 8'd182};
   localparam logic [31:0] SIN_RCP [8] = '{32'd0, 32'(RCP_NUM / 6), 32'(RCP_NUM / 20),
      32'(RCP_NUM / 42), 32'(RCP_NUM / 72), 32'(RCP_NUM / 110), 32'(RCP_NUM / 156),
      32'(RCP_NUM / 210)};
   localparam logic [31:0] COS_RCP [8] = '{32'd0, 32'(RCP_NUM / 2), 32'(RCP_NUM / 12),
      32'(RCP_NUM / 30), 32'(RCP_NUM / 56), 32'(RCP_NUM / 90), 32'(RCP_NUM / 132),
      32'(RCP_NUM / 182)};

   // configuration register indexes
   localparam logic CSR_INTEGRATOR_MODE = 1'b0;
   localparam logic CSR_REWARD_MODE     = 1'b1;

   // step sequencer
   typedef enum logic [5:0] {
      S_IDLE, S_MOD, S_WRAP, S_FOLD, S_XSH, S_SQ, S_TMUL, S_TRCP, S_TFIX, S_SIN,
      S_W1, S_W2, S_W3, S_FADD, S_TEMP, S_NUM, S_TC, S_NSUB, S_C2, S_MPC, S_DSUB,
      S_DEN, S_DINIT, S_DIV, S_DFIN, S_AC, S_AP, S_XACC, S_IMUL, S_IADD, S_DONE
   } state_type;

endpackage

`default_nettype wire

### design/cpds_if.sv
// channel interfaces of the cart-pole step block: request, response, register write
// depends on cpds_pkg for the state format
`timescale 1ns / 1ps
`default_nettype none

interface cpds_req_if;
   import cpds_pkg::*;
   logic   valid;
   logic   ready;
   logic   func;
   logic   push_right;
   fx_type load_position;
   fx_type load_velocity;
   fx_type load_angle;
   fx_type load_angular_rate;
   modport source (output valid, func, push_right, load_position, load_velocity,
                   load_angle, load_angular_rate, input ready);
   modport sink   (input valid, func, push_right, load_position, load_velocity,
                   load_angle, load_angular_rate, output ready);
endinterface

interface cpds_rsp_if;
   import cpds_pkg::*;
   logic              valid;
   logic              ready;
   fx_type            position;
   fx_type            velocity;
   fx_type            angle;
   fx_type            angular_rate;
   logic signed [1:0] reward;
   logic              terminated;
   modport source (output valid, position, velocity, angle, angular_rate, reward,
                   terminated, input ready);
   modport sink   (input valid, position, velocity, angle, angular_rate, reward,
                   terminated, output ready);
endinterface

interface cpds_csr_if;
   logic valid;
   logic ready;
   logic idx;
   logic data;
   modport source (output valid, idx, data, input ready);
   modport sink   (input valid, idx, data, output ready);
endinterface

`default_nettype wire

### design/cart_pole_dynamics_step_top.sv
// Cart-pole physics step. A load item writes the four state values and returns them.
// A step item runs the angle reduction (one compare-subtract per cycle), forty-five
// passes through one shared 32x32 multiplier (sine/cosine series, forces,
// integration) and a 62-step restoring divider for the angular acceleration. The
// block takes no new item while one is in work; a finished item waits in the output
// register and the next request is taken as soon as the sequencer is back in idle.
// Register writes are taken any time, one per cycle, and are meant for when the
// block is idle.
// depends on cpds_pkg and the channel interfaces in cpds_if.sv
`timescale 1ns / 1ps
`default_nettype none

module cart_pole_dynamics_step_top (
   input  wire logic  clock,
   input  wire logic  reset,
   cpds_req_if.sink   req_chan,
   cpds_rsp_if.source rsp_chan,
   cpds_csr_if.sink   csr_chan
);
   import cpds_pkg::*;

   localparam word_type W_ONE30 = WORD_W'(ONE30);

   // saturate a wide signed value to the 32-bit state range
   function automatic word_type sat_w(input logic signed [65:0] v);
      word_type r;
      if (v > 66'sd2147483647) r = 34'sd2147483647;
      else if (v < -66'sd2147483648) r = -34'sd2147483648;
      else r = v[WORD_W-1:0];
      return r;
   endfunction

   function automatic logic [31:0] mag32(input word_type v);
      word_type a;
      a = v[WORD_W-1] ? -v : v;
      return a[31:0];
   endfunction

   // control
   state_type state_ff, state_in;
   logic phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic sel_ff, sel_in;
   logic integ_mode_ff, integ_mode_in;
   logic reward_mode_ff, reward_mode_in;
   logic rsp_valid_ff, rsp_valid_in;

   // cart-pole state
   fx_type pos_ff, pos_in, vel_ff, vel_in, ang_ff, ang_in, rate_ff, rate_in;
   logic func_ff, func_in, push_ff, push_in;

   // angle reduction
   logic [MOD_W-1:0] rem_ff, rem_in;
   logic rneg_ff, rneg_in, flip_ff, flip_in;
   fx_type x_ff, x_in;

   // working values
   word_type q_ff, q_in, ts_ff, ts_in, tc_ff, tc_in, sn_ff, sn_in, cs_ff, cs_in;
   word_type w_ff, w_in, temp_ff, temp_in, num_ff, num_in, den_ff, den_in;
   word_type thacc_ff, thacc_in, xacc_ff, xacc_in, p_ff, p_in;
   logic [31:0] q0_ff, q0_in;

   // shared multiplier
   logic [63:0] prod_ff, prod_in;
   logic mneg_ff, mneg_in;
   word_type opa, opb;
   logic [5:0] msh;
   logic mrnd, msat, is_mul;
   logic [64:0] mround, mmag;
   logic signed [65:0] mres;
   word_type mval;

   // divider
   logic [DIV_STEPS-1:0] dq_ff, dq_in;
   logic [32:0] drem_ff, drem_in, dud_ff, dud_in;
   logic dneg_ff, dneg_in;

   // response payload
   fx_type out_pos_ff, out_pos_in, out_vel_ff, out_vel_in;
   fx_type out_ang_ff, out_ang_in, out_rate_ff, out_rate_in;
   logic signed [1:0] out_reward_ff, out_reward_in;
   logic out_term_ff, out_term_in;

   logic req_fire, term;
   logic [1:0] itgt;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign itgt = {cnt_ff[1], cnt_ff[0] ^ integ_mode_ff};
   assign term = (pos_ff < -X_THR_FX) || (pos_ff > X_THR_FX) ||
                 (ang_ff < -TH_THR_FX) || (ang_ff > TH_THR_FX);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_fire) state_in = req_chan.func ? S_DONE : S_MOD;
         S_MOD:   if (cnt_ff == '0) state_in = S_WRAP;
         S_WRAP:  state_in = S_FOLD;
         S_FOLD:  state_in = S_XSH;
         S_XSH:   state_in = S_SQ;
         S_SQ:    if (phase_ff) state_in = S_TMUL;
         S_TMUL:  if (phase_ff) state_in = S_TRCP;
         S_TRCP:  if (phase_ff) state_in = S_TFIX;
         S_TFIX:  state_in = (sel_ff && cnt_ff[2:0] == 3'd1) ? S_SIN : S_TMUL;
         S_SIN:   if (phase_ff) state_in = S_W1;
         S_W1:    if (phase_ff) state_in = S_W2;
         S_W2:    if (phase_ff) state_in = S_W3;
         S_W3:    if (phase_ff) state_in = S_FADD;
         S_FADD:  state_in = S_TEMP;
         S_TEMP:  if (phase_ff) state_in = S_NUM;
         S_NUM:   if (phase_ff) state_in = S_TC;
         S_TC:    if (phase_ff) state_in = S_NSUB;
         S_NSUB:  state_in = S_C2;
         S_C2:    if (phase_ff) state_in = S_MPC;
         S_MPC:   if (phase_ff) state_in = S_DSUB;
         S_DSUB:  state_in = S_DEN;
         S_DEN:   if (phase_ff) state_in = S_DINIT;
         S_DINIT: state_in = S_DIV;
         S_DIV:   if (cnt_ff == '0) state_in = S_DFIN;
         S_DFIN:  state_in = S_AC;
         S_AC:    if (phase_ff) state_in = S_AP;
         S_AP:    if (phase_ff) state_in = S_XACC;
         S_XACC:  state_in = S_IMUL;
         S_IMUL:  if (phase_ff) state_in = S_IADD;
         S_IADD:  state_in = (cnt_ff[1:0] == 2'd3) ? S_DONE : S_IMUL;
         S_DONE:  if (!rsp_valid_ff || rsp_chan.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and multiplier operand selection
   always_comb begin
      req_chan.ready = (state_ff == S_IDLE);
      csr_chan.ready = 1'b1;
      rsp_chan.valid = rsp_valid_ff;
      rsp_chan.position = out_pos_ff;
      rsp_chan.velocity = out_vel_ff;
      rsp_chan.angle = out_ang_ff;
      rsp_chan.angular_rate = out_rate_ff;
      rsp_chan.reward = out_reward_ff;
      rsp_chan.terminated = out_term_ff;
      is_mul = state_ff inside {S_SQ, S_TMUL, S_TRCP, S_SIN, S_W1, S_W2, S_W3, S_TEMP,
                                S_NUM, S_TC, S_C2, S_MPC, S_DEN, S_AC, S_AP, S_IMUL};
      opa = '0;
      opb = '0;
      msh = SH_30;
      mrnd = 1'b1;
      msat = 1'b0;
      case (state_ff)
         S_SQ:   begin opa = WORD_W'(x_ff); opb = WORD_W'(x_ff); end
         S_TMUL: begin opa = q_ff; opb = sel_ff ? tc_ff : ts_ff; end
         S_TRCP: begin
            opa = p_ff[WORD_W-1] ? -p_ff : p_ff;
            opb = WORD_W'(sel_ff ? COS_RCP[cnt_ff[2:0]] : SIN_RCP[cnt_ff[2:0]]);
            msh = SH_RCP;
            mrnd = 1'b0;
         end
         S_SIN:  begin opa = WORD_W'(x_ff); opb = ts_ff; end
         S_W1:   begin
            opa = WORD_W'(rate_ff); opb = WORD_W'(rate_ff); msh = SH_FX; msat = 1'b1;
         end
         S_W2:   begin opa = w_ff; opb = sn_ff; msat = 1'b1; end
         S_W3:   begin opa = w_ff; opb = WORD_W'(K_PML); msat = 1'b1; end
         S_TEMP: begin opa = w_ff; opb = WORD_W'(K_INV_TM); msat = 1'b1; end
         S_NUM:  begin opa = WORD_W'(KG_FX); opb = sn_ff; msat = 1'b1; end
         S_TC:   begin opa = temp_ff; opb = cs_ff; msat = 1'b1; end
         S_C2:   begin opa = cs_ff; opb = cs_ff; end
         S_MPC:  begin opa = WORD_W'(K_MP_TM); opb = w_ff; end
         S_DEN:  begin opa = WORD_W'(K_LEN); opb = w_ff; end
         S_AC:   begin opa = thacc_ff; opb = cs_ff; msat = 1'b1; end
         S_AP:   begin opa = w_ff; opb = WORD_W'(K_PML_TM); msat = 1'b1; end
         S_IMUL: begin
            case (itgt)
               2'd0:    opa = WORD_W'(vel_ff);
               2'd1:    opa = xacc_ff;
               2'd2:    opa = WORD_W'(rate_ff);
               default: opa = thacc_ff;
            endcase
            opb = WORD_W'(K_TAU);
            msat = 1'b1;
         end
         default: ;
      endcase
   end

   // multiplier: magnitude product is registered, the rounding shift works on the registered product
   always_comb begin
      prod_in = 64'(mag32(opa)) * 64'(mag32(opb));
      mneg_in = opa[WORD_W-1] ^ opb[WORD_W-1];
      mround = {1'b0, prod_ff} + (mrnd ? (65'd1 << (msh - 6'd1)) : 65'd0);
      mmag = mround >> msh;
      mres = mneg_ff ? -$signed({1'b0, mmag}) : $signed({1'b0, mmag});
      mval = msat ? sat_w(mres) : mres[WORD_W-1:0];
   end

   // datapath next values
   always_comb begin
      logic [MOD_W:0] ang_sc;
      logic [MOD_W-1:0] sub_v, xm;
      fx_type xs;
      logic [32:0] ap, qq;
      logic [7:0] dv;
      logic [40:0] prodd, rmd;
      word_type val;
      logic [33:0] trial;
      logic [31:0] an;

      phase_in = is_mul ? ~phase_ff : 1'b0;
      cnt_in = cnt_ff;
      sel_in = sel_ff;
      pos_in = pos_ff; vel_in = vel_ff; ang_in = ang_ff; rate_in = rate_ff;
      func_in = func_ff; push_in = push_ff;
      rem_in = rem_ff; rneg_in = rneg_ff; flip_in = flip_ff; x_in = x_ff;
      q_in = q_ff; ts_in = ts_ff; tc_in = tc_ff; sn_in = sn_ff; cs_in = cs_ff;
      w_in = w_ff; temp_in = temp_ff; num_in = num_ff; den_in = den_ff;
      thacc_in = thacc_ff; xacc_in = xacc_ff; p_in = p_ff; q0_in = q0_ff;
      dq_in = dq_ff; drem_in = drem_ff; dud_in = dud_ff; dneg_in = dneg_ff;
      ang_sc = (MOD_W + 1)'(ang_ff) <<< MOD_SH;
      if (ang_sc[MOD_W]) ang_sc = -ang_sc;
      sub_v = MOD_W'(A_TWO_PI) << cnt_ff;
      xm = (rem_ff + MOD_W'(2)) >> 2;
      xs = FX_W'(xm);
      ap = p_ff[WORD_W-1] ? 33'(-p_ff) : 33'(p_ff);
      dv = sel_ff ? COS_DIV[cnt_ff[2:0]] : SIN_DIV[cnt_ff[2:0]];
      prodd = 41'(q0_ff) * 41'(dv);
      rmd = 41'(ap) - prodd;
      qq = 33'(q0_ff) + 33'(rmd >= 41'(dv));
      val = p_ff[WORD_W-1] ? -word_type'({1'b0, qq}) : word_type'({1'b0, qq});
      trial = {drem_ff, dq_ff[DIV_STEPS-1]};
      an = mag32(num_ff);

      case (state_ff)
         // take an item: load the state or start the angle reduction
         S_IDLE: begin
            if (req_fire) begin
               func_in = req_chan.func;
               push_in = req_chan.push_right;
               if (req_chan.func) begin
                  pos_in = req_chan.load_position;
                  vel_in = req_chan.load_velocity;
                  ang_in = req_chan.load_angle;
                  rate_in = req_chan.load_angular_rate;
               end else begin
                  rem_in = ang_sc[MOD_W-1:0];
                  rneg_in = ang_ff[FX_W-1];
                  flip_in = 1'b0;
                  cnt_in = CNT_W'(MOD_TOP);
               end
            end
         end
         // remainder by two pi, one scaled subtract per cycle
         S_MOD: begin
            if (rem_ff >= sub_v) rem_in = rem_ff - sub_v;
            cnt_in = cnt_ff - CNT_W'(1);
         end
         // wrap to plus/minus pi
         S_WRAP: begin
            if (rem_ff > MOD_W'(A_PI)) begin
               rem_in = MOD_W'(A_TWO_PI) - rem_ff;
               rneg_in = ~rneg_ff;
            end
         end
         // fold to plus/minus pi/2
         S_FOLD: begin
            if (rem_ff > MOD_W'(A_HALF_PI)) begin
               rem_in = MOD_W'(A_PI) - rem_ff;
               flip_in = 1'b1;
            end
         end
         S_XSH: x_in = rneg_ff ? -xs : xs;
         S_SQ: begin
            if (phase_ff) begin
               q_in = mval;
               ts_in = W_ONE30;
               tc_in = W_ONE30;
               cnt_in = CNT_W'(7);
               sel_in = 1'b0;
            end
         end
         S_TMUL: if (phase_ff) p_in = mval;
         S_TRCP: if (phase_ff) q0_in = mval[31:0];
         // quotient correction and horner update
         S_TFIX: begin
            if (sel_ff) begin
               tc_in = W_ONE30 - val;
               sel_in = 1'b0;
               cnt_in = cnt_ff - CNT_W'(1);
            end else begin
               ts_in = W_ONE30 - val;
               sel_in = 1'b1;
            end
         end
         S_SIN: begin
            if (phase_ff) begin
               sn_in = mval;
               cs_in = flip_ff ? -tc_ff : tc_ff;
            end
         end
         S_W1, S_W2, S_W3, S_TC, S_C2, S_MPC, S_AC, S_AP, S_IMUL: begin
            if (phase_ff) w_in = mval;
         end
         S_FADD: begin
            w_in = sat_w(66'(push_ff ? FORCE_FX : -FORCE_FX) + 66'(w_ff));
         end
         S_TEMP: if (phase_ff) temp_in = mval;
         S_NUM:  if (phase_ff) num_in = mval;
         S_NSUB: num_in = sat_w(66'(num_ff) - 66'(w_ff));
         S_DSUB: w_in = WORD_W'(K_FOUR_THIRDS) - w_ff;
         S_DEN:  if (phase_ff) den_in = mval;
         // divider setup: rounded quotient of num * 2^30 by den
         S_DINIT: begin
            dud_in = (den_ff == '0) ? 33'd1 : 33'(mag32(den_ff));
            if (den_ff[WORD_W-1]) dud_in = 33'(-den_ff);
            dq_in = (DIV_STEPS'(an) << 30) + DIV_STEPS'(dud_in >> 1);
            drem_in = '0;
            dneg_in = num_ff[WORD_W-1] ^ den_ff[WORD_W-1];
            cnt_in = CNT_W'(DIV_STEPS - 1);
         end
         S_DIV: begin
            if (trial >= {1'b0, dud_ff}) begin
               drem_in = 33'(trial - {1'b0, dud_ff});
               dq_in = {dq_ff[DIV_STEPS-2:0], 1'b1};
            end else begin
               drem_in = trial[32:0];
               dq_in = {dq_ff[DIV_STEPS-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_W'(1);
         end
         S_DFIN: begin
            thacc_in = sat_w(dneg_ff ? -66'($unsigned(dq_ff)) : 66'($unsigned(dq_ff)));
         end
         S_XACC: begin
            xacc_in = sat_w(66'(temp_ff) - 66'(w_ff));
            cnt_in = '0;
         end
         // integrate one state value
         S_IADD: begin
            case (itgt)
               2'd0:    pos_in = FX_W'(sat_w(66'(pos_ff) + 66'(w_ff)));
               2'd1:    vel_in = FX_W'(sat_w(66'(vel_ff) + 66'(w_ff)));
               2'd2:    ang_in = FX_W'(sat_w(66'(ang_ff) + 66'(w_ff)));
               default: rate_in = FX_W'(sat_w(66'(rate_ff) + 66'(w_ff)));
            endcase
            cnt_in = cnt_ff + CNT_W'(1);
         end
         default: ;
      endcase
   end

   // response register and configuration writes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_pos_in = out_pos_ff;
      out_vel_in = out_vel_ff;
      out_ang_in = out_ang_ff;
      out_rate_in = out_rate_ff;
      out_reward_in = out_reward_ff;
      out_term_in = out_term_ff;
      integ_mode_in = integ_mode_ff;
      reward_mode_in = reward_mode_ff;
      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_chan.ready)) begin
         rsp_valid_in = 1'b1;
         out_pos_in = pos_ff;
         out_vel_in = vel_ff;
         out_ang_in = ang_ff;
         out_rate_in = rate_ff;
         out_term_in = term;
         if (func_ff) out_reward_in = 2'sd0;
         else if (reward_mode_ff) out_reward_in = term ? -2'sd1 : 2'sd0;
         else out_reward_in = 2'sd1;
      end
      if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.idx)
            CSR_INTEGRATOR_MODE: integ_mode_in = csr_chan.data;
            CSR_REWARD_MODE:     reward_mode_in = csr_chan.data;
            default: ;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= 1'b0;
         cnt_ff <= '0;
         sel_ff <= 1'b0;
         integ_mode_ff <= 1'b0;
         reward_mode_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff <= '0;
         vel_ff <= '0;
         ang_ff <= '0;
         rate_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         cnt_ff <= cnt_in;
         sel_ff <= sel_in;
         integ_mode_ff <= integ_mode_in;
         reward_mode_ff <= reward_mode_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff <= pos_in;
         vel_ff <= vel_in;
         ang_ff <= ang_in;
         rate_ff <= rate_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff <= func_in;
      push_ff <= push_in;
      rem_ff <= rem_in;
      rneg_ff <= rneg_in;
      flip_ff <= flip_in;
      x_ff <= x_in;
      q_ff <= q_in;
      ts_ff <= ts_in;
      tc_ff <= tc_in;
      sn_ff <= sn_in;
      cs_ff <= cs_in;
      w_ff <= w_in;
      temp_ff <= temp_in;
      num_ff <= num_in;
      den_ff <= den_in;
      thacc_ff <= thacc_in;
      xacc_ff <= xacc_in;
      p_ff <= p_in;
      q0_ff <= q0_in;
      prod_ff <= prod_in;
      mneg_ff <= mneg_in;
      dq_ff <= dq_in;
      drem_ff <= drem_in;
      dud_ff <= dud_in;
      dneg_ff <= dneg_in;
      out_pos_ff <= out_pos_in;
      out_vel_ff <= out_vel_in;
      out_ang_ff <= out_ang_in;
      out_rate_ff <= out_rate_in;
      out_reward_ff <= out_reward_in;
      out_term_ff <= out_term_in;
   end

endmodule

`default_nettype wire
